@@ rtl/assert_macros.svh @@
// Assertion helper macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/lome_pkg.sv @@
// -----------------------------------------------------------------------------
// lome_pkg
// Shared types and codes for the limit order matching engine.
// -----------------------------------------------------------------------------
`default_nettype none
package lome_pkg;
  localparam logic [1:0] FUNC_NEW    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_UNK  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam int MAX_TRADES = 31;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] order_id;
    logic        side;
    logic [19:0] limit_price;
    logic [23:0] order_qty;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [19:0] trade_price;
    logic [23:0] trade_qty;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/lome_cmd_fifo.sv @@
// -----------------------------------------------------------------------------
// lome_cmd_fifo
// Two-entry command queue between the front intake and the back engine.
// -----------------------------------------------------------------------------
`default_nettype none
module lome_cmd_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_valid,
  output logic             wr_ready,
  input  lome_pkg::cmd_t   wr_data,
  output logic             rd_valid,
  input  wire              rd_ready,
  output lome_pkg::cmd_t   rd_data
);
  import lome_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

@@ rtl/lome_engine.sv @@
// -----------------------------------------------------------------------------
// lome_engine
// Back end: carries out commands on the order table and runs matching by
// scanning one slot per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module lome_engine #(
  parameter int ORDER_SLOTS = 32
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             cmd_valid,
  output logic            cmd_ready,
  input  lome_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  wire             res_ready,
  output lome_pkg::res_t  res
);
  import lome_pkg::*;

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);
  localparam logic [CW-1:0] LAST_SLOT = CW'(ORDER_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOKUP, S_APPLY, S_SCAN, S_TRADE, S_EMIT, S_STATUS
  } state_t;

  state_t       state_r;
  cmd_t         cmd_r;
  logic [ORDER_SLOTS-1:0] valid_r;
  logic [31:0]  id_r    [ORDER_SLOTS];
  logic         side_r  [ORDER_SLOTS];
  logic [19:0]  price_r [ORDER_SLOTS];
  logic [23:0]  qty_r   [ORDER_SLOTS];
  logic [31:0]  seq_r   [ORDER_SLOTS];
  logic [31:0]  seqc_r;
  logic [CW-1:0] idx_r;
  logic         hit_r, free_ok_r;
  logic [IW-1:0] hit_slot_r, free_slot_r;
  logic [1:0]   st_r;
  logic         bok_r, sok_r;
  logic [IW-1:0] b_r, s_r;
  logic [4:0]   ntr_r;
  logic         out_v_r;
  res_t         out_r;

  logic [IW-1:0] ix;
  logic          cur_live, b_better, s_better;
  logic [23:0]   q;
  logic          emit_go;

  assign ix = idx_r[IW-1:0];
  assign cur_live = valid_r[ix] && (qty_r[ix] != 24'd0);
  assign q = (qty_r[b_r] < qty_r[s_r]) ? qty_r[b_r] : qty_r[s_r];
  assign emit_go = ((state_r == S_EMIT) || (state_r == S_STATUS)) && (!out_v_r || res_ready);

  always_comb begin
    b_better = 1'b0;
    if (!bok_r) b_better = 1'b1;
    else if (price_r[ix] != price_r[b_r]) b_better = price_r[ix] > price_r[b_r];
    else b_better = seq_r[ix] < seq_r[b_r];
    s_better = 1'b0;
    if (!sok_r) s_better = 1'b1;
    else if (price_r[ix] != price_r[s_r]) s_better = price_r[ix] < price_r[s_r];
    else s_better = seq_r[ix] < seq_r[s_r];
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = out_v_r;
  assign res       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      seqc_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (emit_go) out_v_r <= 1'b1;
      else if (res_ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r     <= cmd;
            idx_r     <= '0;
            hit_r     <= 1'b0;
            free_ok_r <= 1'b0;
            state_r   <= S_LOOKUP;
          end
        end
        // walk the table for id match and first free slot
        S_LOOKUP: begin
          if (valid_r[ix] && id_r[ix] == cmd_r.order_id && !hit_r) begin
            hit_r      <= 1'b1;
            hit_slot_r <= ix;
          end
          if (!valid_r[ix] && !free_ok_r) begin
            free_ok_r   <= 1'b1;
            free_slot_r <= ix;
          end
          if (idx_r == LAST_SLOT) state_r <= S_APPLY;
          idx_r <= idx_r + 1'b1;
        end
        S_APPLY: begin
          idx_r   <= '0;
          bok_r   <= 1'b0;
          sok_r   <= 1'b0;
          ntr_r   <= '0;
          priority if (cmd_r.func == FUNC_NEW) begin
            state_r <= S_SCAN;
            if (hit_r) st_r <= ST_DUP;
            else if (!free_ok_r) st_r <= ST_FULL;
            else begin
              st_r                 <= ST_OK;
              valid_r[free_slot_r] <= 1'b1;
              id_r[free_slot_r]    <= cmd_r.order_id;
              side_r[free_slot_r]  <= cmd_r.side;
              price_r[free_slot_r] <= cmd_r.limit_price;
              qty_r[free_slot_r]   <= cmd_r.order_qty;
              seq_r[free_slot_r]   <= seqc_r;
              seqc_r               <= seqc_r + 32'd1;
            end
          end else if (cmd_r.func == FUNC_CANCEL) begin
            state_r <= S_STATUS;
            if (hit_r) begin
              st_r                <= ST_OK;
              valid_r[hit_slot_r] <= 1'b0;
            end else st_r <= ST_UNK;
          end else if (cmd_r.func == FUNC_MODIFY) begin
            if (hit_r) begin
              st_r                <= ST_OK;
              price_r[hit_slot_r] <= cmd_r.limit_price;
              qty_r[hit_slot_r]   <= cmd_r.order_qty;
              seq_r[hit_slot_r]   <= seqc_r;
              seqc_r              <= seqc_r + 32'd1;
              state_r             <= S_SCAN;
            end else begin
              st_r    <= ST_UNK;
              state_r <= S_STATUS;
            end
          end else begin
            st_r    <= ST_OK;
            state_r <= S_STATUS;
          end
        end
        // one slot per cycle: track best bid and best ask
        S_SCAN: begin
          if (cur_live && side_r[ix] == SIDE_BUY && b_better) begin
            bok_r <= 1'b1;
            b_r   <= ix;
          end
          if (cur_live && side_r[ix] == SIDE_SELL && s_better) begin
            sok_r <= 1'b1;
            s_r   <= ix;
          end
          if (idx_r == LAST_SLOT) state_r <= S_TRADE;
          idx_r <= idx_r + 1'b1;
        end
        S_TRADE: begin
          if (bok_r && sok_r && price_r[b_r] >= price_r[s_r]
              && ntr_r != 5'(MAX_TRADES)) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_STATUS;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_r.kind        <= KIND_TRADE;
            out_r.status      <= ST_OK;
            out_r.buyer_id    <= id_r[b_r];
            out_r.seller_id   <= id_r[s_r];
            out_r.trade_price <= price_r[b_r];
            out_r.trade_qty   <= q;
            out_r.last        <= 1'b0;
            qty_r[b_r] <= qty_r[b_r] - q;
            qty_r[s_r] <= qty_r[s_r] - q;
            if (qty_r[b_r] == q) valid_r[b_r] <= 1'b0;
            if (qty_r[s_r] == q) valid_r[s_r] <= 1'b0;
            ntr_r   <= ntr_r + 5'd1;
            idx_r   <= '0;
            bok_r   <= 1'b0;
            sok_r   <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_STATUS: begin
          if (emit_go) begin
            out_r.kind        <= KIND_STATUS;
            out_r.status      <= st_r;
            out_r.buyer_id    <= '0;
            out_r.seller_id   <= '0;
            out_r.trade_price <= '0;
            out_r.trade_qty   <= '0;
            out_r.last        <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/limit_order_matching_engine.sv @@
// A cancel, an unused code or a modify of an unknown id gets its status after the table walk;
// a new order or a modify of a live order also rescans the table, and each trade adds a
// fresh table scan; a stall on the output side holds the engine in its emit states.
// The engine takes one command at a time, and the slot-serial table walk sets the rate.
// Reset (rst_n low, synchronous): table empty, sequence zero, queue empty.
// -----------------------------------------------------------------------------
// limit_order_matching_engine
// Price-time priority order book: command queue front, table engine back.
// -----------------------------------------------------------------------------
`default_nettype none
module limit_order_matching_engine #(
  parameter int ORDER_SLOTS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [1:0]   in_func,
  input  wire [31:0]  in_order_id,
  input  wire         in_side,
  input  wire [19:0]  in_limit_price,
  input  wire [23:0]  in_order_qty,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_buyer_id,
  output logic [31:0] out_seller_id,
  output logic [19:0] out_trade_price,
  output logic [23:0] out_trade_qty,
  output logic        out_last
);
  import lome_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  // pack the incoming transaction for the queue
  assign in_cmd = '{func: in_func, order_id: in_order_id, side: in_side,
                    limit_price: in_limit_price, order_qty: in_order_qty};

  lome_cmd_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  lome_engine #(.ORDER_SLOTS(ORDER_SLOTS)) u_engine (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(out_valid), .res_ready(out_ready), .res(res)
  );

  // unpack the result transaction
  assign out_kind        = res.kind;
  assign out_status      = res.status;
  assign out_buyer_id    = res.buyer_id;
  assign out_seller_id   = res.seller_id;
  assign out_trade_price = res.trade_price;
  assign out_trade_qty   = res.trade_qty;
  assign out_last        = res.last;
endmodule
`default_nettype wire

@@ rtl/lome_checker.sv @@
// -----------------------------------------------------------------------------
// lome_checker
// Port-level checks for the matching engine, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lome_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_kind,
  input wire [1:0]  out_status,
  input wire [23:0] out_trade_qty,
  input wire        out_last
);
  import lome_pkg::*;

  `ASSERT_IMPL(a_last_kind, clk, rst_n, out_valid, out_last == out_kind, "last must mark status")
  `ASSERT_IMPL(a_trade_ok, clk, rst_n, out_valid && out_kind == KIND_TRADE, out_status == ST_OK, "trade status")
  `ASSERT_IMPL(a_trade_qty, clk, rst_n, out_valid && out_kind == KIND_TRADE, out_trade_qty != 24'd0, "zero trade")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_last), "hold")
endmodule

bind limit_order_matching_engine lome_checker u_lome_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_kind, .out_status, .out_trade_qty, .out_last
);
`default_nettype wire

@@ tb/sv/lome_checker.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// lome_scoreboard
// Watches the command and result channels of the matching engine, keeps its
// own copy of the order book, predicts trades and status, and counts mismatches.
// -----------------------------------------------------------------------------
module lome_scoreboard #(
  parameter int SLOTS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire [1:0]   in_func,
  input  wire [31:0]  in_order_id,
  input  wire         in_side,
  input  wire [19:0]  in_limit_price,
  input  wire [23:0]  in_order_qty,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire         out_kind,
  input  wire [1:0]   out_status,
  input  wire [31:0]  out_buyer_id,
  input  wire [31:0]  out_seller_id,
  input  wire [19:0]  out_trade_price,
  input  wire [23:0]  out_trade_qty,
  input  wire         out_last,
  output int          fail_count,
  output int          pending,
  output int          trade_count
);
  import lome_pkg::*;

  logic        bk_live [SLOTS];
  logic [31:0] bk_id   [SLOTS];
  logic        bk_side [SLOTS];
  logic [19:0] bk_px   [SLOTS];
  logic [23:0] bk_qty  [SLOTS];
  logic [31:0] bk_seq  [SLOTS];
  logic [31:0] next_seq;
  res_t        expected_results[$];

  function automatic int find_id(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (bk_live[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int best_order(logic sd);
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_live[i] || bk_side[i] != sd || bk_qty[i] == 0) continue;
      if (b < 0) b = i;
      else if (bk_px[i] != bk_px[b]) begin
        if (sd == SIDE_BUY ? bk_px[i] > bk_px[b] : bk_px[i] < bk_px[b]) b = i;
      end else if (bk_seq[i] < bk_seq[b]) b = i;
    end
    return b;
  endfunction

  // Append one expected result at the tail.
  task automatic queue_result(res_t r);
    expected_results = {expected_results, r};
  endtask

  // Cross the book while the best bid reaches the best ask, up to MAX_TRADES trades.
  task automatic cross_book();
    int b, s, n;
    logic [23:0] q;
    res_t r;
    n = 0;
    while (n < MAX_TRADES) begin
      b = best_order(SIDE_BUY);
      s = best_order(SIDE_SELL);
      if (b < 0 || s < 0 || bk_px[b] < bk_px[s]) break;
      q = bk_qty[b] < bk_qty[s] ? bk_qty[b] : bk_qty[s];
      r = '0;
      r.kind = KIND_TRADE;
      r.status = ST_OK;
      r.buyer_id = bk_id[b];
      r.seller_id = bk_id[s];
      r.trade_price = bk_px[b];
      r.trade_qty = q;
      queue_result(r);
      n++;
      bk_qty[b] -= q;
      bk_qty[s] -= q;
      if (bk_qty[b] == 0) bk_live[b] = 1'b0;
      if (bk_qty[s] == 0) bk_live[s] = 1'b0;
    end
  endtask

  task automatic apply_command(cmd_t c);
    int slot;
    logic [1:0] st;
    res_t r;
    st = ST_OK;
    slot = find_id(c.order_id);
    if (c.func == FUNC_NEW) begin
      if (slot >= 0) st = ST_DUP;
      else begin
        for (int i = 0; i < SLOTS && slot < 0; i++)
          if (!bk_live[i]) slot = i;
        if (slot < 0) st = ST_FULL;
        else begin
          bk_live[slot] = 1'b1;
          bk_id[slot] = c.order_id;
          bk_side[slot] = c.side;
          bk_px[slot] = c.limit_price;
          bk_qty[slot] = c.order_qty;
          bk_seq[slot] = next_seq;
          next_seq++;
        end
      end
      cross_book();
    end else if (c.func == FUNC_CANCEL) begin
      if (slot < 0) st = ST_UNK;
      else bk_live[slot] = 1'b0;
    end else if (c.func == FUNC_MODIFY) begin
      if (slot < 0) st = ST_UNK;
      else begin
        bk_px[slot] = c.limit_price;
        bk_qty[slot] = c.order_qty;
        bk_seq[slot] = next_seq;
        next_seq++;
        cross_book();
      end
    end
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.last = 1'b1;
    queue_result(r);
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cmd_t c;
    res_t e;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) bk_live[i] = 1'b0;
      next_seq = '0;
      expected_results.delete();
      fail_count = 0;
      trade_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction kind=%0b", out_kind);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_kind == KIND_TRADE) trade_count++;
          compare_field("kind", 32'(e.kind), 32'(out_kind));
          compare_field("status", 32'(e.status), 32'(out_status));
          compare_field("buyer_id", e.buyer_id, out_buyer_id);
          compare_field("seller_id", e.seller_id, out_seller_id);
          compare_field("trade_price", 32'(e.trade_price), 32'(out_trade_price));
          compare_field("trade_qty", 32'(e.trade_qty), 32'(out_trade_qty));
          compare_field("last", 32'(e.last), 32'(out_last));
        end
      end
      if (in_valid && in_ready) begin
        c.func = in_func;
        c.order_id = in_order_id;
        c.side = in_side;
        c.limit_price = in_limit_price;
        c.order_qty = in_order_qty;
        apply_command(c);
      end
    end
    pending = expected_results.size();
  end
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Drives order book commands into the matching engine: a directed pass over
// the status codes and crossing rules, a long result stall, then random order
// flow with idle bursts and a drain pause. The scoreboard does the comparison.
// -----------------------------------------------------------------------------
module testbench;
  import lome_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_func = '0;
  logic [31:0] in_order_id = '0;
  logic        in_side = 1'b0;
  logic [19:0] in_limit_price = '0;
  logic [23:0] in_order_qty = '0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire         out_kind;
  wire [1:0]   out_status;
  wire [31:0]  out_buyer_id;
  wire [31:0]  out_seller_id;
  wire [19:0]  out_trade_price;
  wire [23:0]  out_trade_qty;
  wire         out_last;
  int          fail_count;
  int          pending;
  int          trade_count;
  int          idle_cycles = 0;
  int          cmd_count = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_results = 1'b0;
  logic [31:0] id_pool[$];

  always #1 clk = ~clk;

  limit_order_matching_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_order_id(in_order_id), .in_side(in_side),
    .in_limit_price(in_limit_price), .in_order_qty(in_order_qty),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_status(out_status),
    .out_buyer_id(out_buyer_id), .out_seller_id(out_seller_id),
    .out_trade_price(out_trade_price), .out_trade_qty(out_trade_qty),
    .out_last(out_last)
  );

  lome_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_order_id(in_order_id), .in_side(in_side),
    .in_limit_price(in_limit_price), .in_order_qty(in_order_qty),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_status(out_status),
    .out_buyer_id(out_buyer_id), .out_seller_id(out_seller_id),
    .out_trade_price(out_trade_price), .out_trade_qty(out_trade_qty),
    .out_last(out_last),
    .fail_count(fail_count), .pending(pending), .trade_count(trade_count)
  );

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, or a hold when asked, or always ready late.
  initial begin : result_sink
    int n;
    @(posedge clk);
    while (1) begin
      if (hold_results) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Drive one command and hold it until accepted. Called right after an edge.
  task automatic send_cmd(logic [1:0] f, logic [31:0] id, logic sd,
                          logic [19:0] px, logic [23:0] q);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_order_id <= id;
    in_side <= sd;
    in_limit_price <= px;
    in_order_qty <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmd_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly ids from a small live set so cancels, modifies and duplicates hit.
  function automatic logic [31:0] pick_id();
    if (id_pool.size() != 0 && $urandom_range(0, 9) < 7)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return $urandom();
  endfunction

  initial begin : stimulus
    logic [31:0] id;
    logic [1:0]  f;
    int          r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: cross at the bid price, partial fill, extremes, codes.
    send_cmd(FUNC_NEW, 32'd1, SIDE_SELL, 20'd100, 24'd10);
    send_cmd(FUNC_NEW, 32'd2, SIDE_BUY, 20'd120, 24'd4);
    send_cmd(FUNC_NEW, 32'd1, SIDE_BUY, 20'd50, 24'd1);
    send_cmd(FUNC_CANCEL, 32'hDEADBEEF, SIDE_BUY, 20'd0, 24'd0);
    send_cmd(FUNC_MODIFY, 32'hDEADBEEF, SIDE_SELL, 20'd9, 24'd9);
    send_cmd(FUNC_RSVD, 32'hFFFFFFFF, SIDE_SELL, 20'hFFFFF, 24'hFFFFFF);
    send_cmd(FUNC_NEW, 32'hFFFFFFFF, SIDE_BUY, 20'hFFFFF, 24'd0);
    send_cmd(FUNC_NEW, 32'd0, SIDE_SELL, 20'd0, 24'hFFFFFF);
    send_cmd(FUNC_MODIFY, 32'hFFFFFFFF, SIDE_BUY, 20'hFFFFF, 24'hFFFFFF);
    send_cmd(FUNC_MODIFY, 32'd1, SIDE_BUY, 20'd0, 24'd0);
    send_cmd(FUNC_CANCEL, 32'd1, SIDE_BUY, 20'd0, 24'd0);
    send_cmd(FUNC_CANCEL, 32'd0, SIDE_BUY, 20'd0, 24'd0);
    // Fill the table with resting bids, then overflow it.
    for (int i = 0; i < 33; i++)
      send_cmd(FUNC_NEW, 32'h100 + i, SIDE_BUY, 20'd10 + i[19:0], 24'd5);
    // Free one slot so the big ask can rest.
    send_cmd(FUNC_CANCEL, 32'h100, SIDE_BUY, 20'd0, 24'd0);
    // One big ask sweeps many bids in a single command.
    send_cmd(FUNC_NEW, 32'h200, SIDE_SELL, 20'd0, 24'hFFFFFF);
    send_cmd(FUNC_CANCEL, 32'h200, SIDE_SELL, 20'd0, 24'd0);
    wait_drained();

    // Stall the result side for a long stretch while commands keep coming.
    hold_results = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_results = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_cmd(FUNC_NEW, 32'h300 + i, i[0], 20'd500, 24'd3);
    join
    wait_drained();

    // Random order flow over a narrow price band so the book crosses often.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - 60) quiet_phase = 1'b1;
      if (k == RANDOM_ITEMS / 2) wait_drained();
      r = $urandom_range(0, 19);
      f = r < 11 ? FUNC_NEW : r < 15 ? FUNC_CANCEL : r < 19 ? FUNC_MODIFY : FUNC_RSVD;
      id = pick_id();
      if (f == FUNC_NEW && id_pool.size() < 40) id_pool = {id_pool, id};
      if ($urandom_range(0, 15) == 0)
        send_cmd(f, id, 1'($urandom_range(0, 1)), 20'($urandom()), 24'($urandom()));
      else
        send_cmd(f, id, 1'($urandom_range(0, 1)), 20'd1000 + 20'($urandom_range(0, 20)),
                 24'($urandom_range(0, 60)));
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("Covered %0d commands with %0d trades: status codes, table overflow,",
             cmd_count, trade_count);
    $display("sweeps, zero-quantity orders, long output stall and drain pauses.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/lome_pkg.sv
rtl/lome_cmd_fifo.sv
rtl/lome_engine.sv
rtl/limit_order_matching_engine.sv
rtl/lome_checker.sv
tb/sv/lome_checker.sv
tb/sv/testbench.sv
